// ===== sv/tist_pkg.sv =====
// ----------------------------------------------------------------------------
// tist_pkg
// shared types and constants for the time interval set table
// ----------------------------------------------------------------------------
package tist_pkg;

  localparam int MAX_INTERVALS = 16;
  localparam int TIME_BITS     = 40;
  localparam int IDX_BITS      = $clog2(MAX_INTERVALS);
  localparam int CNT_BITS      = $clog2(MAX_INTERVALS + 1);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PURGE  = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_SPLIT,
    ST_FIN
  } state_t;

  typedef struct packed {
    op_t                  operation;
    logic [TIME_BITS-1:0] start_time;
    logic [TIME_BITS-1:0] stop_time;
  } req_t;

  typedef struct packed {
    logic                 inside_res;
    logic                 next_found;
    logic [TIME_BITS-1:0] next_time;
    logic                 status;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic eval;
    logic split;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic stop;
    logic split_req;
    logic rsp_full;
  } stat_t;

endpackage

// ===== sv/tist_ctrl.sv =====
// ----------------------------------------------------------------------------
// tist_ctrl
// sequencer: reads and evaluates entries in turn, then commits the result
// ----------------------------------------------------------------------------
module tist_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  tist_pkg::stat_t stat,
  output tist_pkg::cmd_t  cmd
);
  import tist_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = !rst;
        if (req_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (stat.scan_end) begin
          state_next = ST_FIN;
        end else begin
          cmd.rd     = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        priority if (stat.split_req) begin
          state_next = ST_SPLIT;
        end else if (stat.stop) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_SPLIT: begin
        cmd.split  = 1'b1;
        state_next = ST_READ;
      end
      ST_FIN: begin
        if (!stat.rsp_full) begin
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/tist_dp.sv =====
// ----------------------------------------------------------------------------
// tist_dp
// interval storage (two banks), window registers, entry evaluation, result
// ----------------------------------------------------------------------------
module tist_dp (
  input  logic           clk,
  input  logic           rst,
  input  tist_pkg::req_t  req,
  input  tist_pkg::cmd_t  cmd,
  output tist_pkg::stat_t stat,
  input  logic           rsp_ready,
  output logic           rsp_valid,
  output tist_pkg::rsp_t  rsp
);
  import tist_pkg::*;

  localparam int TB = TIME_BITS;

  logic [2*TB-1:0]    mem [2*MAX_INTERVALS];
  logic [2*TB-1:0]    rd_q;
  logic               bank;
  logic [CNT_BITS-1:0] count, idx, n;
  logic [TB-1:0]      win_start, win_stop;
  logic               win_start_set, win_stop_set;
  op_t                op;
  logic [TB-1:0]      b, e;
  logic               hit, err, inside_acc, found;
  logic [TB-1:0]      best;

  logic [TB-1:0]      s, t;
  logic               c1, c2, c3, c4;
  logic               cov, outside, enc;
  logic [TB-1:0]      s2, t2;
  logic               purge_skip;
  logic               f1, f2;
  logic [TB-1:0]      b1, b2;
  logic               we;
  logic [IDX_BITS:0]  waddr;
  logic [2*TB-1:0]    wdata;
  logic               eval_err, eval_hit, eval_keep, fin_full, fin_err;
  logic               win_cond;

  assign s = rd_q[2*TB-1:TB];
  assign t = rd_q[TB-1:0];

  assign c1 = (s <= b) && (t >= e);
  assign c2 = (s >= b) && (t <= e);
  assign c3 = (t >= b) && (t <= e);
  assign c4 = (s >= b) && (s <= e);

  assign cov     = (s >= b) && (t <= e);
  assign outside = (t < b) || (s > e);
  assign enc     = (s < b) && (t > e) && !outside;
  assign s2      = ((s > b) && (s < e)) ? e : s;
  assign t2      = ((t > b) && (t < e)) ? b : t;

  assign purge_skip = !win_start_set || (e < win_start);

  assign f1 = (s > b) && (!found || (s < best));
  assign b1 = f1 ? s : best;
  assign f2 = (t > b) && (!(found || f1) || (t < b1));
  assign b2 = f2 ? t : b1;

  assign eval_hit  = (op == OP_ADD) && (c1 || c2 || c3 || c4);
  assign eval_keep = (op == OP_REMOVE) && !cov && !enc;
  assign eval_err  = (op == OP_REMOVE) &&
                     ((eval_keep && (n >= CNT_BITS'(MAX_INTERVALS))) ||
                      (!cov && enc && (n + CNT_BITS'(2) > CNT_BITS'(MAX_INTERVALS))));

  assign fin_full = (op == OP_ADD) && !hit && (count >= CNT_BITS'(MAX_INTERVALS));
  assign fin_err  = err || fin_full;
  assign win_cond = !win_start_set || (b < win_start) || !win_stop_set || (b > win_stop);

  assign stat.scan_end  = (idx == count) || ((op == OP_PURGE) && purge_skip);
  assign stat.stop      = eval_hit || eval_err;
  assign stat.split_req = (op == OP_REMOVE) && !cov && enc && !eval_err;
  assign stat.rsp_full  = rsp_valid && !rsp_ready;

  always_comb begin
    we    = 1'b0;
    waddr = {bank, idx[IDX_BITS-1:0]};
    wdata = rd_q;
    if (cmd.eval) begin
      unique case (op)
        OP_ADD: begin
          priority if (c1) begin
            we = 1'b0;
          end else if (c2) begin
            we = 1'b1; wdata = {b, e};
          end else if (c3) begin
            we = 1'b1; wdata = {s, e};
          end else if (c4) begin
            we = 1'b1; wdata = {b, t};
          end
        end
        OP_REMOVE: begin
          waddr = {~bank, n[IDX_BITS-1:0]};
          if (!eval_err && !cov) begin
            we = 1'b1;
            priority if (outside) begin
              wdata = {s, t};
            end else if (enc) begin
              wdata = {s, b};
            end else begin
              wdata = {s2, t2};
            end
          end
        end
        OP_PURGE: begin
          waddr = {bank, n[IDX_BITS-1:0]};
          we    = (t >= e);
        end
        OP_QUERY: we = 1'b0;
        default: we = 1'b0;
      endcase
    end else if (cmd.split) begin
      we    = 1'b1;
      waddr = {~bank, n[IDX_BITS-1:0]};
      wdata = {e, t};
    end else if (cmd.fin && (op == OP_ADD) && !hit && !fin_full) begin
      we    = 1'b1;
      waddr = {bank, count[IDX_BITS-1:0]};
      wdata = {b, e};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rd_q <= mem[{bank, idx[IDX_BITS-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op         <= req.operation;
      b          <= req.start_time;
      e          <= req.stop_time;
      idx        <= '0;
      n          <= '0;
      hit        <= 1'b0;
      err        <= 1'b0;
      inside_acc <= 1'b0;
      found      <= 1'b0;
      best       <= '0;
    end else if (cmd.eval) begin
      idx <= idx + CNT_BITS'(1);
      hit <= eval_hit;
      err <= eval_err;
      if (op == OP_QUERY) begin
        inside_acc <= inside_acc || ((b > s) && (b < t));
        found      <= found || f1 || f2;
        best       <= b2;
      end
      if ((eval_keep && !eval_err) || ((op == OP_PURGE) && (t >= e)) ||
          ((op == OP_REMOVE) && enc && !cov && !eval_err)) begin
        n <= n + CNT_BITS'(1);
      end
    end else if (cmd.split) begin
      n <= n + CNT_BITS'(1);
    end
    if (cmd.fin) begin
      rsp.inside_res <= (op == OP_QUERY) && (inside_acc || win_cond);
      rsp.next_found <= (op == OP_QUERY) && found;
      rsp.next_time  <= ((op == OP_QUERY) && found) ? best : '0;
      rsp.status     <= fin_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank          <= 1'b0;
      count         <= '0;
      win_start     <= '0;
      win_stop      <= '0;
      win_start_set <= 1'b0;
      win_stop_set  <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cmd.fin) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cmd.fin) begin
        if (((op == OP_ADD) || (op == OP_REMOVE)) && !fin_err) begin
          if (!win_start_set || (b < win_start)) begin
            win_start     <= b;
            win_start_set <= 1'b1;
          end
          if (!win_stop_set || (e > win_stop)) begin
            win_stop     <= e;
            win_stop_set <= 1'b1;
          end
        end
        if ((op == OP_ADD) && !hit && !fin_full) begin
          count <= count + CNT_BITS'(1);
        end
        if ((op == OP_REMOVE) && !err) begin
          bank  <= ~bank;
          count <= n;
        end
        if ((op == OP_PURGE) && !purge_skip) begin
          win_start <= e;
          count     <= n;
        end
      end
    end
  end

endmodule

// ===== sv/time_interval_set_table.sv =====
// ----------------------------------------------------------------------------
// time_interval_set_table
// ordered interval table with validity window: add, remove, purge, query
//
//   channel  dir  signals                  content
//   req      in   req_valid/req_ready/req  operation, start_time, stop_time
//   rsp      out  rsp_valid/rsp_ready/rsp  inside_res, next_found, next_time,
//                                          status
//
// one transaction reads and evaluates each stored entry scanned in turn,
// plus a split step for each split; the single read port of the entry
// memory sets this. add stops at its first matching entry.
// synchronous reset empties the table at once; no clearing pass.
// a pending response does not block the next request; only a second
// finished result waits while rsp is stalled.
// ----------------------------------------------------------------------------
module time_interval_set_table (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  tist_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output tist_pkg::rsp_t  rsp
);
  import tist_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tist_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tist_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

// ===== sv/tist_chk.sv =====
// ----------------------------------------------------------------------------
// tist_chk
// port-level checks for the time interval set table
// ----------------------------------------------------------------------------
module tist_chk (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input tist_pkg::rsp_t rsp
);
  import tist_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("rsp changed while stalled");

  a_no_next: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.next_found |-> rsp.next_time == '0)
    else $error("next_time without next_found");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status |-> !rsp.inside_res && !rsp.next_found)
    else $error("query fields set on dropped transaction");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid after reset");

  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

endmodule

bind time_interval_set_table tist_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
